### rtl/rpacs_pkg.sv
// shared types and constants of the raster paint store
`default_nettype none

package rpacs_pkg;

  localparam int COORD_W    = 16;
  localparam int PIX_W      = 32;
  localparam int CAP_W      = 8;
  localparam int DIM_W      = 9;
  localparam int ACT_W      = 2;
  localparam int ALPHA_LSB  = 24;
  localparam int IN_DATA_W  = 72;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  typedef enum logic [ACT_W-1:0] {
    ACT_PAINT = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAYER_WIDTH  = 2'd0,
    REG_LAYER_HEIGHT = 2'd1,
    REG_CLEAR_COLOR  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    action_e            kind;
    logic               in_layer;
    logic [PIX_W-1:0]   sample;
    logic [CAP_W-1:0]   cap;
  } cmd_t;

  localparam int CMD_W = ACT_W + 1 + PIX_W + CAP_W;

endpackage

`default_nettype wire

### rtl/rpacs_queue.sv
// small command queue between front and back
`default_nettype none

module rpacs_queue #(
  parameter int WIDTH = 67
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);
  import rpacs_pkg::*;

  logic [WIDTH-1:0]  entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rpacs_front.sv
// front end: accepts items, bounds check, address compute, classification
`default_nettype none

module rpacs_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [rpacs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  wire logic [rpacs_pkg::ACT_W-1:0]    s_axis_tuser,
  input  wire logic [rpacs_pkg::DIM_W-1:0]    layer_width_i,
  input  wire logic [rpacs_pkg::DIM_W-1:0]    layer_height_i,
  input  wire logic                           q_full_i,
  input  wire logic                           sweep_i,
  output logic                                push_o,
  output rpacs_pkg::cmd_t                     cmd_o,
  output logic [AW-1:0]                       addr_o
);
  import rpacs_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);

  logic [COORD_W-1:0] pos_x, pos_y;
  logic [XW-1:0]      eff_w;
  logic [YW-1:0]      eff_h;
  logic               in_layer;
  logic               keep;
  action_e            act;

  assign pos_x = s_axis_tdata[15:0];
  assign pos_y = s_axis_tdata[31:16];
  assign act   = action_e'(s_axis_tuser);

  // oversized dimensions saturate
  assign eff_w = (32'(layer_width_i) > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(layer_width_i);
  assign eff_h = (32'(layer_height_i) > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
                                                          : YW'(layer_height_i);

  assign in_layer = !pos_x[COORD_W-1] && !pos_y[COORD_W-1]
                 && (32'(pos_x[COORD_W-2:0]) < 32'(eff_w))
                 && (32'(pos_y[COORD_W-2:0]) < 32'(eff_h));

  assign addr_o = AW'(32'(pos_y[COORD_W-2:0]) * 32'(eff_w) + 32'(pos_x[COORD_W-2:0]));

  always_comb begin
    case (act)
      ACT_PAINT: keep = in_layer;
      ACT_READ:  keep = 1'b1;
      ACT_CLEAR: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  assign s_axis_tready = !q_full_i && !sweep_i;
  assign push_o        = s_axis_tvalid && s_axis_tready && keep;

  assign cmd_o.kind     = act;
  assign cmd_o.in_layer = in_layer;
  assign cmd_o.sample   = s_axis_tdata[63:32];
  assign cmd_o.cap      = s_axis_tdata[71:64];

endmodule

`default_nettype wire

### rtl/rpacs_back.sv
// back end: pixel memory, alpha update, read results and clear sweep
`default_nettype none

module rpacs_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int AW         = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire rpacs_pkg::cmd_t            q_cmd_i,
  input  wire logic [AW-1:0]              q_addr_i,
  output logic                            pop_o,
  output logic                            sweep_o,
  input  wire logic [rpacs_pkg::PIX_W-1:0] clear_color_i,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [rpacs_pkg::PIX_W-1:0]     m_axis_tdata,
  output logic                            m_axis_tuser
);
  import rpacs_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT
  } state_e;

  state_e             state_q;
  logic [AW-1:0]      clr_cnt_q;
  logic [AW-1:0]      cur_addr_q;
  logic [PIX_W-1:0]   cur_sample_q;
  logic [CAP_W-1:0]   cur_cap_q;
  logic               m_valid_q, m_inside_q;
  logic               m_valid_d;
  logic [PIX_W-1:0]   m_data_q;

  // memory word: written flag above the pixel
  logic [PIX_W:0]     store_mem [DEPTH];
  logic [PIX_W:0]     rd_q;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [PIX_W:0]     mem_wdata;

  logic               slot_free;
  logic [PIX_W-1:0]   cur_pixel;
  logic [7:0]         old_a, smp_a, new_a;
  logic [8:0]         sum_a;

  assign slot_free = !m_valid_q || m_axis_tready;
  assign pop_o     = (state_q == ST_IDLE) && q_valid_i
                  && ((q_cmd_i.kind != ACT_READ) || slot_free);
  assign sweep_o   = (state_q == ST_CLEAR);

  // result loads from the result state or from an outside read
  assign m_valid_d = (state_q == ST_RESULT)
                  || (pop_o && (q_cmd_i.kind == ACT_READ) && !q_cmd_i.in_layer)
                  || (m_valid_q && !m_axis_tready);

  assign cur_pixel = rd_q[PIX_W] ? rd_q[PIX_W-1:0] : clear_color_i;
  assign old_a     = cur_pixel[PIX_W-1:ALPHA_LSB];
  assign smp_a     = cur_sample_q[PIX_W-1:ALPHA_LSB];
  assign sum_a     = {1'b0, old_a} + {1'b0, smp_a};

  always_comb begin
    if (old_a >= cur_cap_q) begin
      new_a = old_a;
    end else if (sum_a > {1'b0, cur_cap_q}) begin
      new_a = cur_cap_q;
    end else begin
      new_a = sum_a[7:0];
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = q_addr_i;
    mem_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_q;
      end
      ST_UPDATE: begin
        mem_we    = 1'b1;
        mem_addr  = cur_addr_q;
        mem_wdata = {1'b1, new_a, cur_sample_q[ALPHA_LSB-1:0]};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_addr] <= mem_wdata;
    end else begin
      rd_q <= store_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      cur_addr_q   <= '0;
      cur_sample_q <= '0;
      cur_cap_q    <= '0;
      m_valid_q    <= 1'b0;
      m_inside_q   <= 1'b0;
      m_data_q     <= '0;
    end else begin
      m_valid_q <= m_valid_d;
      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            cur_addr_q   <= q_addr_i;
            cur_sample_q <= q_cmd_i.sample;
            cur_cap_q    <= q_cmd_i.cap;
            case (q_cmd_i.kind)
              ACT_PAINT: state_q <= ST_UPDATE;
              ACT_READ: begin
                if (q_cmd_i.in_layer) begin
                  state_q <= ST_RESULT;
                end else begin
                  m_data_q   <= '0;
                  m_inside_q <= 1'b0;
                end
              end
              ACT_CLEAR: begin
                clr_cnt_q <= '0;
                state_q   <= ST_CLEAR;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_UPDATE: state_q <= ST_IDLE;
        ST_RESULT: begin
          m_data_q   <= cur_pixel;
          m_inside_q <= 1'b1;
          state_q    <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_inside_q;

  a_clear_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_cmd_i.kind == ACT_CLEAR) |=> (state_q == ST_CLEAR && clr_cnt_q == '0))
    else $error("clear did not start a sweep at address zero");

  a_sweep_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && clr_cnt_q != LAST_ADDR) |=> (state_q == ST_CLEAR))
    else $error("sweep left before the last address");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_RESULT || $past(state_q) == ST_IDLE))
    else $error("result raised from a wrong state");

endmodule

`default_nettype wire

### rtl/raster_paint_alpha_capped_store_unit.sv
// raster paint store: a read item passes the queue, the memory read and the result register
// (an outside read skips the memory read); paint reads in the idle state, writes in update
// a 4-entry command queue decouples input acceptance from the memory side
// a clear sweeps all MAX_WIDTH*MAX_HEIGHT addresses; input is held off while it runs
// after reset the same sweep over all MAX_WIDTH*MAX_HEIGHT addresses runs before any item is taken
`default_nettype none

module raster_paint_alpha_capped_store_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, sample_color, opacity_cap
  input  wire logic [rpacs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  wire logic [rpacs_pkg::ACT_W-1:0]      s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // pixel_value
  output logic [rpacs_pkg::PIX_W-1:0]           m_axis_tdata,
  // inside_res
  output logic                                  m_axis_tuser,
  input  wire logic                             cfg_we_i,
  input  wire logic [rpacs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rpacs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rpacs_pkg::*;

  localparam int AW = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int QW = AW + CMD_W;

  logic [DIM_W-1:0] layer_width_q, layer_height_q;
  logic [PIX_W-1:0] clear_color_q;

  logic             push, q_full, q_valid, pop, sweep;
  cmd_t             front_cmd, back_cmd;
  logic [AW-1:0]    front_addr, back_addr;
  logic [QW-1:0]    q_rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_width_q  <= DIM_RESET;
      layer_height_q <= DIM_RESET;
      clear_color_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_LAYER_WIDTH:  layer_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_LAYER_HEIGHT: layer_height_q <= cfg_data_i[DIM_W-1:0];
        REG_CLEAR_COLOR:  clear_color_q  <= cfg_data_i[PIX_W-1:0];
        default:          clear_color_q  <= clear_color_q;
      endcase
    end
  end

  rpacs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .layer_width_i (layer_width_q),
    .layer_height_i(layer_height_q),
    .q_full_i      (q_full),
    .sweep_i       (sweep),
    .push_o        (push),
    .cmd_o         (front_cmd),
    .addr_o        (front_addr)
  );

  rpacs_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({front_addr, front_cmd}),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .data_o     (q_rd_data)
  );

  assign back_cmd  = cmd_t'(q_rd_data[CMD_W-1:0]);
  assign back_addr = q_rd_data[QW-1 -: AW];

  rpacs_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .AW        (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cmd_i      (back_cmd),
    .q_addr_i     (back_addr),
    .pop_o        (pop),
    .sweep_o      (sweep),
    .clear_color_i(clear_color_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

`default_nettype wire
